FILE: design/trpd_pkg.sv
`timescale 1ns / 1ps

package trpd_pkg;

  // Header layout and accepted format
  localparam int unsigned HeaderBytes  = 18;
  localparam int unsigned ImageTypeRle = 10;
  localparam int unsigned PixelBits    = 32;
  localparam int unsigned RunFlagBit   = 7;

  // Header byte offsets
  localparam int unsigned OffIdLen    = 0;
  localparam int unsigned OffMapType  = 1;
  localparam int unsigned OffImgType  = 2;
  localparam int unsigned OffOrgFirst = 8;
  localparam int unsigned OffOrgLast  = 11;
  localparam int unsigned OffWidthLo  = 12;
  localparam int unsigned OffWidthHi  = 13;
  localparam int unsigned OffHeightLo = 14;
  localparam int unsigned OffHeightHi = 15;
  localparam int unsigned OffPixBits  = 16;

  // Stream widths
  localparam int unsigned OutDataW = 80;

  typedef enum logic [1:0] {
    KIND_PIXEL_RUN = 2'd0,
    KIND_HDR_OK    = 2'd1,
    KIND_HDR_BAD   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_COLOR_MAP = 3'd1,
    ERR_IMG_TYPE  = 3'd2,
    ERR_PIX_BITS  = 3'd3,
    ERR_ORIGIN    = 3'd4,
    ERR_OVERRUN   = 3'd5
  } err_e;

  // One input byte with its start-of-file flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } item_t;

  // Registered input item as seen by the parser
  typedef struct packed {
    logic  valid;
    item_t item;
  } in_slot_t;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] pixel_rgba;
    logic [7:0]  run_length;
    logic [15:0] image_width;
    logic [15:0] image_height;
    err_e        error_code;
    logic        last_run;
  } result_t;

  // Parser output toward the result register
  typedef struct packed {
    logic    valid;
    result_t res;
  } res_slot_t;

endpackage

FILE: design/trpd_in_stage.sv
`timescale 1ns / 1ps

module trpd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  trpd_pkg::item_t     s_item_i,
  input  logic                consume_i,
  output trpd_pkg::in_slot_t  slot_o
);

  logic            valid_q, valid_d;
  trpd_pkg::item_t item_q;
  logic            load;

  // Slot frees up in the same cycle the parser takes it
  assign s_ready_o = !valid_q || consume_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= s_item_i;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.item  = item_q;

endmodule

FILE: design/trpd_parser.sv
`timescale 1ns / 1ps

module trpd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trpd_pkg::in_slot_t  slot_i,
  input  logic                advance_i,
  output trpd_pkg::res_slot_t res_o
);

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_HEAD   = 3'd1,
    PH_SKIP   = 3'd2,
    PH_PACKET = 3'd3,
    PH_COLOR  = 3'd4
  } phase_e;

  localparam logic [4:0] HdrLastIdx = 5'(trpd_pkg::HeaderBytes - 1);

  phase_e      phase_q, phase_d;
  logic [4:0]  hidx_q, hidx_d;
  logic [7:0]  id_left_q, id_left_d;
  logic [7:0]  map_type_q, map_type_d;
  logic [7:0]  img_type_q, img_type_d;
  logic [7:0]  pix_bits_q, pix_bits_d;
  logic        org_nz_q, org_nz_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [31:0] pix_left_q, pix_left_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic        pkt_run_q, pkt_run_d;
  logic [23:0] color_q, color_d;
  logic [1:0]  cidx_q, cidx_d;

  // Current view: a start flag drops the file before the byte is parsed
  phase_e      ph_cur;
  logic [4:0]  hidx_cur;
  logic [7:0]  id_left_cur, map_type_cur, img_type_cur, pix_bits_cur;
  logic        org_nz_cur;
  logic [15:0] width_cur, height_cur;
  logic [31:0] pix_left_cur;
  logic [7:0]  pkt_left_cur;
  logic        pkt_run_cur;
  logic [23:0] color_cur;
  logic [1:0]  cidx_cur;

  logic [7:0]  b;
  logic        fs;
  logic [31:0] pix_total;
  logic [7:0]  run_n;
  logic [31:0] pix_after;
  trpd_pkg::err_e    hdr_err;
  trpd_pkg::err_e    run_err;
  trpd_pkg::res_slot_t res;

  assign b  = slot_i.item.data_byte;
  assign fs = slot_i.item.file_start;

  always_comb begin
    ph_cur       = fs ? PH_HEAD : phase_q;
    hidx_cur     = fs ? '0 : hidx_q;
    id_left_cur  = fs ? '0 : id_left_q;
    map_type_cur = fs ? '0 : map_type_q;
    img_type_cur = fs ? '0 : img_type_q;
    pix_bits_cur = fs ? '0 : pix_bits_q;
    org_nz_cur   = fs ? 1'b0 : org_nz_q;
    width_cur    = fs ? '0 : width_q;
    height_cur   = fs ? '0 : height_q;
    pix_left_cur = fs ? '0 : pix_left_q;
    pkt_left_cur = fs ? '0 : pkt_left_q;
    pkt_run_cur  = fs ? 1'b0 : pkt_run_q;
    color_cur    = fs ? '0 : color_q;
    cidx_cur     = fs ? '0 : cidx_q;
  end

  // Image size, only used on the last header byte
  assign pix_total = 32'(width_cur) * 32'(height_cur);

  // Header checks in priority order
  always_comb begin
    if (map_type_cur != 8'd0) begin
      hdr_err = trpd_pkg::ERR_COLOR_MAP;
    end else if (img_type_cur != 8'(trpd_pkg::ImageTypeRle)) begin
      hdr_err = trpd_pkg::ERR_IMG_TYPE;
    end else if (pix_bits_cur != 8'(trpd_pkg::PixelBits)) begin
      hdr_err = trpd_pkg::ERR_PIX_BITS;
    end else if (org_nz_cur) begin
      hdr_err = trpd_pkg::ERR_ORIGIN;
    end else begin
      hdr_err = trpd_pkg::ERR_NONE;
    end
  end

  // Run length clipped to the pixels still owed
  always_comb begin
    run_err = trpd_pkg::ERR_NONE;
    if (pkt_run_cur) begin
      if (32'(pkt_left_cur) > pix_left_cur) begin
        run_n   = pix_left_cur[7:0];
        run_err = trpd_pkg::ERR_OVERRUN;
      end else begin
        run_n = pkt_left_cur;
      end
    end else begin
      run_n = 8'd1;
    end
  end

  assign pix_after = pix_left_cur - 32'(run_n);

  // Next state and result
  always_comb begin
    phase_d    = ph_cur;
    hidx_d     = hidx_cur;
    id_left_d  = id_left_cur;
    map_type_d = map_type_cur;
    img_type_d = img_type_cur;
    pix_bits_d = pix_bits_cur;
    org_nz_d   = org_nz_cur;
    width_d    = width_cur;
    height_d   = height_cur;
    pix_left_d = pix_left_cur;
    pkt_left_d = pkt_left_cur;
    pkt_run_d  = pkt_run_cur;
    color_d    = color_cur;
    cidx_d     = cidx_cur;

    res.valid            = 1'b0;
    res.res.kind         = trpd_pkg::KIND_PIXEL_RUN;
    res.res.pixel_rgba   = '0;
    res.res.run_length   = '0;
    res.res.image_width  = width_cur;
    res.res.image_height = height_cur;
    res.res.error_code   = trpd_pkg::ERR_NONE;
    res.res.last_run     = 1'b0;

    case (ph_cur)
      PH_HEAD: begin
        case (hidx_cur)
          5'(trpd_pkg::OffIdLen):    id_left_d       = b;
          5'(trpd_pkg::OffMapType):  map_type_d      = b;
          5'(trpd_pkg::OffImgType):  img_type_d      = b;
          5'(trpd_pkg::OffWidthLo):  width_d[7:0]    = b;
          5'(trpd_pkg::OffWidthHi):  width_d[15:8]   = b;
          5'(trpd_pkg::OffHeightLo): height_d[7:0]   = b;
          5'(trpd_pkg::OffHeightHi): height_d[15:8]  = b;
          5'(trpd_pkg::OffPixBits):  pix_bits_d      = b;
          default: begin
            if (hidx_cur >= 5'(trpd_pkg::OffOrgFirst) &&
                hidx_cur <= 5'(trpd_pkg::OffOrgLast) && b != 8'd0) begin
              org_nz_d = 1'b1;
            end
          end
        endcase

        if (hidx_cur != HdrLastIdx) begin
          hidx_d = hidx_cur + 5'd1;
        end else begin
          hidx_d    = '0;
          res.valid = 1'b1;
          if (hdr_err != trpd_pkg::ERR_NONE) begin
            phase_d            = PH_WAIT;
            res.res.kind       = trpd_pkg::KIND_HDR_BAD;
            res.res.error_code = hdr_err;
          end else begin
            pix_left_d   = pix_total;
            res.res.kind = trpd_pkg::KIND_HDR_OK;
            if (width_cur == 16'd0 || height_cur == 16'd0) begin
              // empty image completes on the header item
              phase_d          = PH_WAIT;
              res.res.last_run = 1'b1;
            end else if (id_left_cur != 8'd0) begin
              phase_d = PH_SKIP;
            end else begin
              phase_d = PH_PACKET;
            end
          end
        end
      end

      PH_SKIP: begin
        id_left_d = id_left_cur - 8'd1;
        if (id_left_d == 8'd0) begin
          phase_d = PH_PACKET;
        end
      end

      PH_PACKET: begin
        pkt_run_d  = b[trpd_pkg::RunFlagBit];
        pkt_left_d = {1'b0, b[trpd_pkg::RunFlagBit-1:0]} + 8'd1;
        color_d    = '0;
        cidx_d     = '0;
        phase_d    = PH_COLOR;
      end

      PH_COLOR: begin
        if (cidx_cur != 2'd3) begin
          case (cidx_cur)
            2'd0:    color_d[7:0]   = b;
            2'd1:    color_d[15:8]  = b;
            default: color_d[23:16] = b;
          endcase
          cidx_d = cidx_cur + 2'd1;
        end else begin
          color_d    = '0;
          cidx_d     = '0;
          pix_left_d = pix_after;
          pkt_left_d = pkt_run_cur ? 8'd0 : pkt_left_cur - 8'd1;

          res.valid          = 1'b1;
          res.res.kind       = trpd_pkg::KIND_PIXEL_RUN;
          // stored B,G,R,A word rotated left by one byte
          res.res.pixel_rgba = {color_cur, b};
          res.res.run_length = run_n;
          res.res.error_code = run_err;

          if (pix_after == 32'd0) begin
            res.res.last_run = 1'b1;
            if (!pkt_run_cur && pkt_left_d != 8'd0) begin
              res.res.error_code = trpd_pkg::ERR_OVERRUN;
            end
            phase_d = PH_WAIT;
          end else if (pkt_left_d == 8'd0) begin
            phase_d = PH_PACKET;
          end
        end
      end

      default: begin
        // waiting for a start flag: byte dropped
      end
    endcase

    res.valid = res.valid && slot_i.valid;
  end

  assign res_o = res;

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      hidx_q     <= '0;
      id_left_q  <= '0;
      map_type_q <= '0;
      img_type_q <= '0;
      pix_bits_q <= '0;
      org_nz_q   <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      pix_left_q <= '0;
      pkt_left_q <= '0;
      pkt_run_q  <= 1'b0;
      color_q    <= '0;
      cidx_q     <= '0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      hidx_q     <= hidx_d;
      id_left_q  <= id_left_d;
      map_type_q <= map_type_d;
      img_type_q <= img_type_d;
      pix_bits_q <= pix_bits_d;
      org_nz_q   <= org_nz_d;
      width_q    <= width_d;
      height_q   <= height_d;
      pix_left_q <= pix_left_d;
      pkt_left_q <= pkt_left_d;
      pkt_run_q  <= pkt_run_d;
      color_q    <= color_d;
      cidx_q     <= cidx_d;
    end
  end

endmodule

FILE: design/trpd_out_stage.sv
`timescale 1ns / 1ps

module trpd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trpd_pkg::res_slot_t  res_i,
  output logic                 can_load_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output trpd_pkg::result_t    m_res_o
);

  logic              valid_q, valid_d;
  trpd_pkg::result_t res_q;
  logic              load;

  // Register is free when empty or drained this cycle
  assign can_load_o = !valid_q || m_ready_i;
  assign load       = can_load_o && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i.res;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

FILE: design/tga_rle_pixel_decoder_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                  Contents
// s_axis    in   tvalid tready tdata tuser  one file byte, start-of-file flag
// m_axis    out  tvalid tready tdata tuser  pixel run or header verdict
//                tlast                     image complete
//
// One byte per cycle while m_axis is not stalled; a byte that yields a result
// passes through the input register, parse logic and result register in turn.
// The input register is freed in the cycle the parser consumes it, so a
// full result register that is draining does not stall the input.
// Reset clears the handshake and parse state; the parser waits for a
// start-of-file byte.
module tga_rle_pixel_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] file_start

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] pixel_rgba, [39:32] run_length, [55:40] image_width,
  // [71:56] image_height, [74:72] error_code, [79:75] zero
  output logic [trpd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast   // last_run
);

  trpd_pkg::item_t     s_item;
  trpd_pkg::in_slot_t  in_slot;
  trpd_pkg::res_slot_t res_slot;
  trpd_pkg::result_t   m_res;
  logic                can_load;
  logic                consume;

  assign s_item.data_byte  = s_axis_tdata;
  assign s_item.file_start = s_axis_tuser;

  // Parser steps whenever a byte is held and the result side has room
  assign consume = in_slot.valid && can_load;

  trpd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .consume_i (consume),
    .slot_o    (in_slot)
  );

  trpd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .slot_i    (in_slot),
    .advance_i (consume),
    .res_o     (res_slot)
  );

  trpd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res_slot),
    .can_load_o (can_load),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_res_o    (m_res)
  );

  // Pack result fields, lowest first
  assign m_axis_tdata = {5'd0, m_res.error_code, m_res.image_height,
                         m_res.image_width, m_res.run_length, m_res.pixel_rgba};
  assign m_axis_tuser = m_res.kind;
  assign m_axis_tlast = m_res.last_run;

`ifndef SYNTHESIS
  // A rejected header never completes an image and always names a cause
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_res.kind == trpd_pkg::KIND_HDR_BAD
    |-> !m_res.last_run && m_res.error_code != trpd_pkg::ERR_NONE)
    else $error("rejected header with bad code or last flag");

  // Pixel runs are never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_res.kind == trpd_pkg::KIND_PIXEL_RUN
    |-> m_res.run_length != 8'd0)
    else $error("pixel run with zero length");

  // An accepted header carries no error and no color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_res.kind == trpd_pkg::KIND_HDR_OK
    |-> m_res.error_code == trpd_pkg::ERR_NONE && m_res.pixel_rgba == 32'd0)
    else $error("accepted header with error or color");

  // A held byte stays held while the result side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_slot.valid && m_axis_tvalid && !m_axis_tready |=> in_slot.valid)
    else $error("input byte lost during output stall");
`endif

endmodule
